@@ rtl/nfr_pkg.sv @@
// shared types and constants for the frame receiver
`timescale 1ns / 1ps
`default_nettype none

package nfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 17;

  localparam logic [ByteW-1:0]   StartByteRst = 8'd254;
  localparam logic [OffsetW-1:0] MaxStoredRst = 17'd128;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STORED = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_CMD0    = 3'd3,
    PH_CMD1    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  typedef struct packed {
    logic               in_frame;
    logic               stored;
    logic [OffsetW-1:0] position;
    logic [ByteW-1:0]   frame_byte;
    logic               frame_end;
    logic               frame_ok;
    logic [WordW-1:0]   payload_length;
    logic [WordW-1:0]   command_word;
    logic [WordW-1:0]   check_fail_count;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/nfr_parser.sv @@
// frame parser: per-byte state update and result for one received byte
`timescale 1ns / 1ps
`default_nettype none

module nfr_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         take_i,
  input  wire logic [nfr_pkg::ByteW-1:0]    rx_byte_i,
  input  wire logic [nfr_pkg::ByteW-1:0]    start_byte_i,
  input  wire logic [nfr_pkg::OffsetW-1:0]  max_stored_i,
  output nfr_pkg::result_t                  res_o
);
  import nfr_pkg::*;

  phase_e             phase_q, phase_d;
  logic [WordW-1:0]   length_q, length_d;
  logic [WordW-1:0]   left_q, left_d;
  logic [ByteW-1:0]   xor_q, xor_d;
  logic [WordW-1:0]   cmd_q, cmd_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [WordW-1:0]   fails_q, fails_d;
  logic               in_frame;
  logic               stored;
  logic               frame_end;
  logic               frame_ok;
  logic               fits;

  assign fits = (offset_q < max_stored_i);

  // next state
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    left_d   = left_q;
    xor_d    = xor_q;
    cmd_d    = cmd_q;
    fails_d  = fails_q;
    unique case (phase_q)
      PH_LEN_LO: begin
        length_d = {length_q[WordW-1:ByteW], rx_byte_i};
        xor_d    = xor_q ^ rx_byte_i;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d = {rx_byte_i, length_q[ByteW-1:0]};
        xor_d    = xor_q ^ rx_byte_i;
        phase_d  = PH_CMD0;
      end
      PH_CMD0: begin
        cmd_d   = {cmd_q[WordW-1:ByteW], rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PH_CMD1;
      end
      PH_CMD1: begin
        cmd_d   = {rx_byte_i, cmd_q[ByteW-1:0]};
        xor_d   = xor_q ^ rx_byte_i;
        left_d  = length_q;
        phase_d = (length_q == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        xor_d  = xor_q ^ rx_byte_i;
        left_d = left_q - WordW'(1);
        if (left_d == '0) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (!frame_ok && (fails_q != '1)) begin
          fails_d = fails_q + WordW'(1);
        end
        phase_d = PH_HUNT;
      end
      default: begin
        // unused codes behave as hunting
        phase_d = PH_HUNT;
        if (rx_byte_i == start_byte_i) begin
          xor_d   = '0;
          phase_d = PH_LEN_LO;
        end
      end
    endcase
  end

  // per-byte flags
  always_comb begin
    in_frame  = 1'b1;
    stored    = 1'b1;
    frame_end = 1'b0;
    frame_ok  = 1'b0;
    unique case (phase_q) inside
      PH_LEN_LO, PH_LEN_HI, PH_CMD0, PH_CMD1: begin
        // header bytes are always stored
      end
      PH_PAYLOAD: begin
        stored = fits;
      end
      PH_CHECK: begin
        stored    = fits;
        frame_end = 1'b1;
        frame_ok  = (rx_byte_i == xor_q);
      end
      default: begin
        if (rx_byte_i != start_byte_i) begin
          in_frame = 1'b0;
          stored   = 1'b0;
        end
      end
    endcase
  end

  // offset restarts on the start byte, advances on every frame byte
  always_comb begin
    offset_d = offset_q;
    if (in_frame) begin
      offset_d = ((phase_q == PH_CHECK) || (phase_q == PH_LEN_LO) || (phase_q == PH_LEN_HI) ||
                  (phase_q == PH_CMD0) || (phase_q == PH_CMD1) || (phase_q == PH_PAYLOAD))
                 ? offset_q + OffsetW'(1) : OffsetW'(1);
    end
  end

  always_comb begin
    res_o                  = '0;
    res_o.in_frame         = in_frame;
    res_o.stored           = stored;
    res_o.frame_byte       = rx_byte_i;
    res_o.frame_end        = frame_end;
    res_o.frame_ok         = frame_ok;
    res_o.check_fail_count = fails_d;
    if (in_frame) begin
      res_o.position = (offset_d == OffsetW'(1)) && !frame_end &&
                       (phase_q != PH_LEN_LO) && (phase_q != PH_LEN_HI) &&
                       (phase_q != PH_CMD0) && (phase_q != PH_CMD1) &&
                       (phase_q != PH_PAYLOAD) ? '0 : offset_q;
    end
    if (frame_end) begin
      res_o.payload_length = length_q;
      res_o.command_word   = cmd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      length_q <= '0;
      left_q   <= '0;
      xor_q    <= '0;
      cmd_q    <= '0;
      offset_q <= '0;
      fails_q  <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      left_q   <= left_d;
      xor_q    <= xor_d;
      cmd_q    <= cmd_d;
      offset_q <= offset_d;
      fails_q  <= fails_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/npi_frame_receiver_core.sv @@
// frame receiver top level: config registers, parser and output register
// output: the result item of an accepted byte is registered and appears on the outputs in the next cycle
// throughput: one byte per cycle; the output register takes a new item whenever
// it is empty or its item is taken in the same cycle
// reset: parser returns to hunting with all counters and fields cleared,
// start byte 254 and buffer capacity 128
`timescale 1ns / 1ps
`default_nettype none

module npi_frame_receiver_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [nfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [nfr_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [nfr_pkg::ByteW-1:0]    rx_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              in_frame_o,
  output logic                              stored_o,
  output logic [nfr_pkg::OffsetW-1:0]       position_o,
  output logic [nfr_pkg::ByteW-1:0]         frame_byte_o,
  output logic                              frame_end_o,
  output logic                              frame_ok_o,
  output logic [nfr_pkg::WordW-1:0]         payload_length_o,
  output logic [nfr_pkg::WordW-1:0]         command_word_o,
  output logic [nfr_pkg::WordW-1:0]         check_fail_count_o
);
  import nfr_pkg::*;

  logic [ByteW-1:0]   start_byte_q;
  logic [OffsetW-1:0] max_stored_q;
  logic               take;
  logic               out_valid_q, out_valid_d;
  result_t            res;
  result_t            res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
      max_stored_q <= MaxStoredRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_BYTE: start_byte_q <= cfg_data_i[ByteW-1:0];
        CFG_MAX_STORED: max_stored_q <= cfg_data_i[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // accept while the output register is empty or drains this cycle
  assign in_stall_o = out_valid_q & out_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  nfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .rx_byte_i    (rx_byte_i),
    .start_byte_i (start_byte_q),
    .max_stored_i (max_stored_q),
    .res_o        (res)
  );

  assign out_valid_d = take | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign in_frame_o         = res_q.in_frame;
  assign stored_o           = res_q.stored;
  assign position_o         = res_q.position;
  assign frame_byte_o       = res_q.frame_byte;
  assign frame_end_o        = res_q.frame_end;
  assign frame_ok_o         = res_q.frame_ok;
  assign payload_length_o   = res_q.payload_length;
  assign command_word_o     = res_q.command_word;
  assign check_fail_count_o = res_q.check_fail_count;

endmodule

`default_nettype wire
